/* sv/bf_tape_machine_macros.svh */
// assertion macros used by the checker file of bf_tape_machine
// no dependencies; take in with an include by bare file name
`ifndef BF_TAPE_MACHINE_MACROS_SVH
`define BF_TAPE_MACHINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bftm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BFTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bftm assertion failed");

`endif

/* sv/bftm_pkg.sv */
// types, sizes and character codes for the bf_tape_machine block
// no dependencies; used by the top level and the checker
package bftm_pkg;

  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned TAPE_DEPTH = 32768;

  localparam int unsigned PROG_AW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int unsigned PROG_CW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TAPE_AW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;

  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_RBRACK = 8'd93;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_LEFT   = 8'd60;
  localparam logic [7:0] CH_RIGHT  = 8'd62;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HALT     = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] prog_byte;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_char;
    logic [1:0] status;
  } result_t;

endpackage

/* sv/bftm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module bftm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/bf_tape_machine.sv */
// bf_tape_machine top level: program loader with bracket pairing and a stepper
// depends on bftm_pkg and bftm_ram
//
//  channel   handshake            payload
//  input     start / busy         item_i   (cmd, prog_byte)
//  result    done_o (one cycle)   result_o (out_valid, out_char, status)
//
// a load answers from idle; a load of ']' that closes a pair passes S_JW1 and S_JW2,
// since both jump table entries go through the single write port of that ram
// a step reads program, jump table and tape through registered ram ports, then
// the instruction executes in S_EXEC and '+' or '-' writes the cell back
// errors, halt and a full program store answer straight from idle
// after reset the tape is swept to zero, one cell a cycle, with busy high throughout
// the result is held for no one: done_o marks it for exactly one cycle
module bf_tape_machine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bftm_pkg::item_t   item_i,
  output logic              done_o,
  output bftm_pkg::result_t result_o
);
  import bftm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_JW1  = 2'd2;
  localparam logic [1:0] S_JW2  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [PROG_CW-1:0] len_q, len_d;
  logic [PROG_CW-1:0] sd_q, sd_d;
  logic [PROG_CW-1:0] instr_q, instr_d;
  logic [TAPE_AW-1:0] cell_q, cell_d;
  logic               mm_q, mm_d;
  logic [PROG_AW-1:0] pos_q, pos_d;
  logic [PROG_AW-1:0] left_q, left_d;
  logic               clr_active_q;
  logic [TAPE_AW-1:0] clr_addr_q;
  logic               done_q, done_d;
  result_t            res_q, res_d;

  logic               accept;
  logic               prog_we;
  logic [7:0]         prog_rdata;
  logic               stack_we;
  logic [PROG_AW-1:0] stack_rdata;
  logic               jump_we;
  logic [PROG_AW-1:0] jump_waddr;
  logic [PROG_AW-1:0] jump_wdata;
  logic [PROG_AW-1:0] jump_rdata;
  logic               exec_we;
  logic [7:0]         exec_wdata;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [7:0]         tape_wdata;
  logic [7:0]         tape_rdata;
  logic [1:0]         load_status;

  assign busy        = clr_active_q || (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign load_status = mm_q ? ST_MISMATCH : ST_OK;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    sd_d       = sd_q;
    instr_d    = instr_q;
    cell_d     = cell_q;
    mm_d       = mm_q;
    pos_d      = pos_q;
    left_d     = left_q;
    done_d     = 1'b0;
    res_d      = '0;
    prog_we    = 1'b0;
    stack_we   = 1'b0;
    jump_we    = 1'b0;
    jump_waddr = pos_q;
    jump_wdata = left_q;
    exec_we    = 1'b0;
    exec_wdata = tape_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.cmd == CMD_LOAD) begin
            if (len_q >= PROG_CW'(PROG_DEPTH)) begin
              done_d       = 1'b1;
              res_d.status = ST_FULL;
            end else begin
              prog_we = 1'b1;
              len_d   = len_q + PROG_CW'(1);
              if (item_i.prog_byte == CH_LBRACK) begin
                if (sd_q < PROG_CW'(PROG_DEPTH)) begin
                  stack_we = 1'b1;
                  sd_d     = sd_q + PROG_CW'(1);
                end
                done_d       = 1'b1;
                res_d.status = load_status;
              end else if (item_i.prog_byte == CH_RBRACK) begin
                if (sd_q == '0) begin
                  mm_d         = 1'b1;
                  done_d       = 1'b1;
                  res_d.status = ST_MISMATCH;
                end else begin
                  // partner position arrives from the stack ram next cycle
                  sd_d    = sd_q - PROG_CW'(1);
                  pos_d   = len_q[PROG_AW-1:0];
                  state_d = S_JW1;
                end
              end else begin
                done_d       = 1'b1;
                res_d.status = load_status;
              end
            end
          end else begin
            if (mm_q || (sd_q != '0)) begin
              done_d       = 1'b1;
              res_d.status = ST_MISMATCH;
            end else if (instr_q >= len_q) begin
              done_d       = 1'b1;
              res_d.status = ST_HALT;
            end else begin
              state_d = S_EXEC;
            end
          end
        end
      end
      S_EXEC: begin
        state_d      = S_IDLE;
        done_d       = 1'b1;
        res_d.status = ST_OK;
        instr_d      = instr_q + PROG_CW'(1);
        unique case (prog_rdata)
          CH_LEFT: begin
            cell_d = (cell_q == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : cell_q - TAPE_AW'(1);
          end
          CH_RIGHT: begin
            cell_d = (cell_q == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : cell_q + TAPE_AW'(1);
          end
          CH_PLUS: begin
            exec_we    = 1'b1;
            exec_wdata = tape_rdata + 8'd1;
          end
          CH_MINUS: begin
            exec_we    = 1'b1;
            exec_wdata = tape_rdata - 8'd1;
          end
          CH_DOT: begin
            res_d.out_valid = 1'b1;
            res_d.out_char  = tape_rdata;
          end
          CH_LBRACK: begin
            if (tape_rdata == 8'd0) begin
              instr_d = PROG_CW'(jump_rdata) + PROG_CW'(1);
            end
          end
          CH_RBRACK: begin
            if (tape_rdata != 8'd0) begin
              instr_d = PROG_CW'(jump_rdata) + PROG_CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_JW1: begin
        jump_we    = 1'b1;
        jump_waddr = stack_rdata;
        jump_wdata = pos_q;
        left_d     = stack_rdata;
        state_d    = S_JW2;
      end
      S_JW2: begin
        jump_we      = 1'b1;
        jump_waddr   = pos_q;
        jump_wdata   = left_q;
        done_d       = 1'b1;
        res_d.status = load_status;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // zero sweep after reset has the tape write port to itself
  assign tape_we    = clr_active_q || exec_we;
  assign tape_waddr = clr_active_q ? clr_addr_q : cell_q;
  assign tape_wdata = clr_active_q ? 8'd0 : exec_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= '0;
      sd_q         <= '0;
      instr_q      <= '0;
      cell_q       <= TAPE_AW'(TAPE_DEPTH / 2);
      mm_q         <= 1'b0;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      sd_q    <= sd_d;
      instr_q <= instr_d;
      cell_q  <= cell_d;
      mm_q    <= mm_d;
      done_q  <= done_d;
      if (clr_active_q) begin
        if (clr_addr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
          clr_active_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + TAPE_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    left_q <= left_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  bftm_ram #(.Width(8), .Depth(PROG_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (len_q[PROG_AW-1:0]),
    .wdata_i (item_i.prog_byte),
    .raddr_i (instr_q[PROG_AW-1:0]),
    .rdata_o (prog_rdata)
  );

  bftm_ram #(.Width(PROG_AW), .Depth(PROG_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (sd_q[PROG_AW-1:0]),
    .wdata_i (len_q[PROG_AW-1:0]),
    .raddr_i (sd_d[PROG_AW-1:0]),
    .rdata_o (stack_rdata)
  );

  bftm_ram #(.Width(PROG_AW), .Depth(PROG_DEPTH)) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (jump_we),
    .waddr_i (jump_waddr),
    .wdata_i (jump_wdata),
    .raddr_i (instr_q[PROG_AW-1:0]),
    .rdata_o (jump_rdata)
  );

  bftm_ram #(.Width(8), .Depth(TAPE_DEPTH)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (cell_q),
    .rdata_o (tape_rdata)
  );

endmodule

/* sv/bftm_checker.sv */
// port-level checks for bf_tape_machine, attached by the bind at the end
// depends on bftm_pkg and bf_tape_machine_macros.svh
`include "bf_tape_machine_macros.svh"

module bftm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_i,
  input bftm_pkg::result_t result_i
);
  import bftm_pkg::*;

  // an accepted item either keeps the block busy or answers at once
  `BFTM_ASSERT_NXT(a_accept_answers, clk_i, rst_ni, start && !busy, busy || done_i)

  // a result only follows an accepted item or a busy cycle
  `BFTM_ASSERT_IMP(a_done_has_cause, clk_i, rst_ni, done_i, $past(start && !busy) || $past(busy))

  // an emitted character only comes with ok status
  `BFTM_ASSERT_IMP(a_char_ok, clk_i, rst_ni, done_i && result_i.out_valid, result_i.status == ST_OK)

  // no character means a zero char field
  `BFTM_ASSERT_IMP(a_char_zero, clk_i, rst_ni, done_i && !result_i.out_valid, result_i.out_char == 8'd0)

endmodule

bind bf_tape_machine bftm_checker u_bftm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_i   (done_o),
  .result_i (result_o)
);
